### src/mwto_pkg.sv
// ----------------------------------------------------------------------------
// Test oscillator package
// Shared types, register map, waveform codes and fixed-point constants.
// ----------------------------------------------------------------------------
package mwto_pkg;

   typedef enum logic [2:0] {
      WAVE_SINE     = 3'd0,
      WAVE_DC       = 3'd1,
      WAVE_SILENT   = 3'd2,
      WAVE_SQUARE   = 3'd3,
      WAVE_TRIANGLE = 3'd4,
      WAVE_RAMP     = 3'd5,
      WAVE_IMPULSE  = 3'd6,
      WAVE_PULSE    = 3'd7
   } mwto_wave_type;

   typedef enum logic [2:0] {
      FILL_ANGLE,
      FILL_SQUARE,
      FILL_MUL,
      FILL_DIV,
      FILL_ACC,
      FILL_SCALE,
      FILL_WRITE,
      FILL_DONE
   } mwto_fill_state_type;

   // register indexes (word address bits)
   localparam logic [2:0] REG_WAVE_MODE       = 3'd0;
   localparam logic [2:0] REG_AMPLITUDE       = 3'd1;
   localparam logic [2:0] REG_FREQ_STEP       = 3'd2;
   localparam logic [2:0] REG_TONE_SAMPLES    = 3'd3;
   localparam logic [2:0] REG_SILENCE_SAMPLES = 3'd4;

   localparam logic signed [15:0] AMPLITUDE_RESET = 16'sd32767;
   localparam logic [30:0]        FREQ_RESET      = 31'd39370534;
   localparam logic [31:0]        TONE_RESET      = 32'd48000;
   localparam logic [31:0]        SILENCE_RESET   = 32'd0;

   typedef struct packed {
      mwto_wave_type      wave_mode;
      logic signed [15:0] amplitude;
      logic [30:0]        freq_step;
      logic [31:0]        tone_samples;
      logic [31:0]        silence_samples;
   } mwto_cfg_type;

   // one classified sample on its way to the multiplier
   typedef struct packed {
      logic               is_sine;
      logic signed [33:0] operand;     // Q31 factor, or table index for sine
      logic               in_silence;
      logic               last_sample;
      logic               finished;
   } mwto_job_type;

   localparam int TABLE_WIDTH = 16;
   localparam int OUT_DEPTH   = 4;
   localparam int MID_DEPTH   = 2;

   // angles in Q30
   localparam logic [32:0] PI_Q30       = 33'd3373259426;
   localparam logic [32:0] TWOPI_Q30    = 33'd6746518852;
   localparam logic [32:0] HALFPI_Q30   = 33'd1686629713;
   localparam logic [32:0] THREEHALF_Q30 = 33'd5059889139;

   localparam logic signed [33:0] PHASE_HALF = 34'sd2147483648;
   localparam logic signed [35:0] WIDE_HALF  = 36'sd2147483648;

   localparam logic [2:0] LAST_TERM = 3'd6;

   // reciprocals of (n+1)(n+2) for the odd Taylor terms up to x^15:
   // floor(v / d) = (v * M) >> s for every 32-bit v
   function automatic logic [32:0] taylor_recip(input logic [2:0] term);
      logic [32:0] m;
      case (term)
         3'd0: m = 33'd5726623062;   // 6
         3'd1: m = 33'd6871947674;   // 20
         3'd2: m = 33'd6544712071;   // 42
         3'd3: m = 33'd7635497416;   // 72
         3'd4: m = 33'd4997780127;   // 110
         3'd5: m = 33'd7048151461;   // 156
         3'd6: m = 33'd5235769657;   // 210
         default: m = 33'd0;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] taylor_shift(input logic [2:0] term);
      logic [5:0] s;
      case (term)
         3'd0: s = 6'd35;
         3'd1: s = 6'd37;
         3'd2: s = 6'd38;
         3'd3: s = 6'd39;
         3'd4: s = 6'd39;
         3'd5: s = 6'd40;
         3'd6: s = 6'd40;
         default: s = 6'd32;
      endcase
      return s;
   endfunction

endpackage

### src/multi_waveform_test_oscillator.sv
// ----------------------------------------------------------------------------
// Multi-waveform test oscillator
// A result word passes the job queue, multiplier pipeline and result queue.
// Throughput is one tick per cycle unless the result queue backs up: front end
// and multiplier pipeline each take one word a cycle, joined by a two-word queue.
// After reset the sine table is built one entry at a time; full stays high
// until then. Register writes work throughout.
// ----------------------------------------------------------------------------
module multi_waveform_test_oscillator
   import mwto_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int SAMPLE_WIDTH     = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic                    req_restart,
   output logic                    empty,
   input  logic                    pop,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample,
   output logic                    rsp_in_silence,
   output logic                    rsp_last_sample,
   output logic                    rsp_finished,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [4:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
   localparam int JOB_W     = $bits(mwto_job_type);
   localparam int OUT_W     = SAMPLE_WIDTH + 3;
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

   mwto_cfg_type cfg_ff, cfg_in;

   logic                   table_ready;
   logic                   fill_we;
   logic [IDX_W-1:0]       fill_addr;
   logic [TABLE_WIDTH-1:0] fill_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [TABLE_WIDTH-1:0] rd_data;

   logic                   accept;
   mwto_job_type           front_job;
   mwto_job_type           mid_job;
   logic [JOB_W-1:0]       mid_word;
   logic                   mid_full, mid_empty, mid_pop;
   logic [MID_CNT_W-1:0]   mid_count;

   logic                   out_push, out_full;
   logic [OUT_W-1:0]       out_wdata, out_rdata;
   logic [OUT_CNT_W-1:0]   out_count;
   logic                   cfg_write;

   // configuration registers
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (paddr[4:2])
            REG_WAVE_MODE:       cfg_in.wave_mode       = mwto_wave_type'(pwdata[2:0]);
            REG_AMPLITUDE:       cfg_in.amplitude       = signed'(pwdata[15:0]);
            REG_FREQ_STEP:       cfg_in.freq_step       = pwdata[30:0];
            REG_TONE_SAMPLES:    cfg_in.tone_samples    = pwdata;
            REG_SILENCE_SAMPLES: cfg_in.silence_samples = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_WAVE_MODE:       prdata = {29'd0, cfg_ff.wave_mode};
         REG_AMPLITUDE:       prdata = {16'd0, cfg_ff.amplitude};
         REG_FREQ_STEP:       prdata = {1'b0, cfg_ff.freq_step};
         REG_TONE_SAMPLES:    prdata = cfg_ff.tone_samples;
         REG_SILENCE_SAMPLES: prdata = cfg_ff.silence_samples;
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_mode       <= WAVE_SINE;
         cfg_ff.amplitude       <= AMPLITUDE_RESET;
         cfg_ff.freq_step       <= FREQ_RESET;
         cfg_ff.tone_samples    <= TONE_RESET;
         cfg_ff.silence_samples <= SILENCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sine table
   mwto_table_fill #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_fill (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (fill_we),
      .wr_addr    (fill_addr),
      .wr_data    (fill_data),
      .table_ready(table_ready)
   );

   mwto_ram #(
      .WIDTH(TABLE_WIDTH),
      .DEPTH(SINE_TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (fill_we),
      .wr_addr(fill_addr),
      .wr_data(fill_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // front end
   assign full   = !table_ready || mid_full;
   assign accept = push && !full;

   mwto_front #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .restart(req_restart),
      .job    (front_job)
   );

   mwto_fifo #(
      .WIDTH(JOB_W),
      .DEPTH(MID_DEPTH)
   ) u_mid_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (accept),
      .wr_data(front_job),
      .pop    (mid_pop),
      .rd_data(mid_word),
      .full   (mid_full),
      .empty  (mid_empty),
      .count  (mid_count)
   );

   assign mid_job = mwto_job_type'(mid_word);

   // back end
   mwto_back #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
      .SAMPLE_WIDTH    (SAMPLE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .amplitude(cfg_ff.amplitude),
      .job      (mid_job),
      .job_valid(!mid_empty),
      .job_pop  (mid_pop),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .out_count(out_count),
      .out_push (out_push),
      .out_word (out_wdata)
   );

   mwto_fifo #(
      .WIDTH(OUT_W),
      .DEPTH(OUT_DEPTH)
   ) u_out_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (out_push),
      .wr_data(out_wdata),
      .pop    (pop),
      .rd_data(out_rdata),
      .full   (out_full),
      .empty  (empty),
      .count  (out_count)
   );

   assign rsp_sample      = out_rdata[OUT_W-1:3];
   assign rsp_in_silence  = out_rdata[2];
   assign rsp_last_sample = out_rdata[1];
   assign rsp_finished    = out_rdata[0];

   // checks
   a_no_out_overflow : assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result word written into a full queue");

   a_table_frozen : assert property (@(posedge clock) disable iff (reset)
      fill_we |-> !table_ready)
      else $error("sine table written after it was marked ready");

   a_mid_pop_valid : assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> (!mid_empty && (mid_count != '0)))
      else $error("back end popped an empty job queue");

   a_no_tick_before_table : assert property (@(posedge clock) disable iff (reset)
      !table_ready |=> mid_empty)
      else $error("tick accepted while the sine table was still being built");

endmodule

### src/mwto_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mwto_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mwto_fifo.sv
// ----------------------------------------------------------------------------
// Small register FIFO
// Holds words between the oscillator stages; head word shown combinationally.
// ----------------------------------------------------------------------------
module mwto_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### src/mwto_table_fill.sv
// ----------------------------------------------------------------------------
// Sine table builder
// After reset computes each table entry with a Q30 odd Taylor series,
// multipliers for the square, the term products and the scaling, and a
// reciprocal multiplication for each constant divisor, and writes it.
// ----------------------------------------------------------------------------
module mwto_table_fill
   import mwto_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   output logic                                wr_en,
   output logic [$clog2(SINE_TABLE_DEPTH)-1:0] wr_addr,
   output logic [TABLE_WIDTH-1:0]              wr_data,
   output logic                                table_ready
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam logic [32:0]      X_STEP  = 33'(TWOPI_Q30 / SINE_TABLE_DEPTH);
   localparam logic [IDX_W:0]   X_REM   = (IDX_W + 1)'(TWOPI_Q30 % SINE_TABLE_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_W = (IDX_W + 1)'(SINE_TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_K  = IDX_W'(SINE_TABLE_DEPTH - 1);

   mwto_fill_state_type state_ff, state_in;

   logic [IDX_W-1:0]   k_ff, k_in;
   logic [32:0]        x_ff, x_in;
   logic [IDX_W:0]     xrem_ff, xrem_in;
   logic signed [31:0] xa_ff, xa_in;
   logic [31:0]        x2_ff, x2_in;
   logic [30:0]        tmag_ff, tmag_in;
   logic               tneg_ff, tneg_in;
   logic signed [32:0] sum_ff, sum_in;
   logic [2:0]         term_ff, term_in;
   logic [31:0]        dvd_ff, dvd_in;
   logic signed [48:0] v_ff, v_in;

   logic signed [34:0] angle;
   logic signed [31:0] xa_calc;
   logic [31:0]        xa_mag;
   logic signed [63:0] square;
   logic [61:0]        mul_prod;
   logic [32:0]        recip;
   logic [5:0]         recip_shift;
   logic [64:0]        recip_prod;
   logic [30:0]        quot;
   logic signed [32:0] q_term;
   logic [IDX_W:0]     rem_sum;
   logic [48:0]        v_mag;
   logic [48:0]        v_round;
   logic [15:0]        v_clamp;

   // fold the angle into -pi/2 .. pi/2
   always_comb begin
      angle = signed'({2'b00, x_ff});
      if (x_ff > HALFPI_Q30) begin
         if (x_ff < THREEHALF_Q30) begin
            angle = signed'({2'b00, PI_Q30}) - signed'({2'b00, x_ff});
         end else begin
            angle = signed'({2'b00, x_ff}) - signed'({2'b00, TWOPI_Q30});
         end
      end
      xa_calc = angle[31:0];
      xa_mag  = xa_calc[31] ? 32'(-xa_calc) : 32'(xa_calc);
   end

   // |term| * x2 stays below 2^62 since |x| <= pi/2
   assign square      = 64'(xa_ff) * 64'(xa_ff);
   assign mul_prod    = 62'(tmag_ff) * 62'(x2_ff);
   assign recip       = taylor_recip(term_ff);
   assign recip_shift = taylor_shift(term_ff);
   assign recip_prod  = 65'(dvd_ff) * 65'(recip);
   assign quot        = 31'(recip_prod >> recip_shift);
   assign q_term      = signed'({2'b00, tmag_ff});
   assign rem_sum     = xrem_ff + X_REM;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FILL_ANGLE:  state_in = FILL_SQUARE;
         FILL_SQUARE: state_in = FILL_MUL;
         FILL_MUL:    state_in = FILL_DIV;
         FILL_DIV:    state_in = FILL_ACC;
         FILL_ACC:    state_in = (term_ff == LAST_TERM) ? FILL_SCALE : FILL_MUL;
         FILL_SCALE:  state_in = FILL_WRITE;
         FILL_WRITE:  state_in = (k_ff == LAST_K) ? FILL_DONE : FILL_ANGLE;
         FILL_DONE:   state_in = FILL_DONE;
         default:     state_in = FILL_DONE;
      endcase
   end

   // outputs
   always_comb begin
      v_mag   = v_ff[48] ? 49'(-v_ff) : 49'(v_ff);
      v_round = (v_mag + 49'd536870912) >> 30;
      v_clamp = (v_round > 49'd32767) ? 16'd32767 : v_round[15:0];
      wr_en       = (state_ff == FILL_WRITE);
      wr_addr     = k_ff;
      wr_data     = v_ff[48] ? 16'(-v_clamp) : v_clamp;
      table_ready = (state_ff == FILL_DONE);
   end

   // datapath
   always_comb begin
      k_in    = k_ff;
      x_in    = x_ff;
      xrem_in = xrem_ff;
      xa_in   = xa_ff;
      x2_in   = x2_ff;
      tmag_in = tmag_ff;
      tneg_in = tneg_ff;
      sum_in  = sum_ff;
      term_in = term_ff;
      dvd_in  = dvd_ff;
      v_in    = v_ff;
      case (state_ff)
         FILL_ANGLE: begin
            xa_in   = xa_calc;
            tmag_in = xa_mag[30:0];
            tneg_in = xa_calc[31];
            sum_in  = 33'(xa_calc);
            term_in = '0;
         end
         FILL_SQUARE: begin
            x2_in = square[61:30];
         end
         FILL_MUL: begin
            dvd_in = mul_prod[61:30];
         end
         FILL_DIV: begin
            // next term: magnitude divided by (n+1)(n+2), sign flipped
            tmag_in = quot;
            tneg_in = !tneg_ff;
         end
         FILL_ACC: begin
            sum_in  = tneg_ff ? sum_ff - q_term : sum_ff + q_term;
            term_in = term_ff + 1'b1;
         end
         FILL_SCALE: begin
            v_in = 49'(sum_ff) * 49'sd32767;
         end
         FILL_WRITE: begin
            k_in = k_ff + 1'b1;
            if (rem_sum >= DEPTH_W) begin
               xrem_in = rem_sum - DEPTH_W;
               x_in    = x_ff + X_STEP + 33'd1;
            end else begin
               xrem_in = rem_sum;
               x_in    = x_ff + X_STEP;
            end
         end
         FILL_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FILL_ANGLE;
         k_ff     <= '0;
         x_ff     <= '0;
         xrem_ff  <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         x_ff     <= x_in;
         xrem_ff  <= xrem_in;
         term_ff  <= term_in;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff   <= xa_in;
      x2_ff   <= x2_in;
      tmag_ff <= tmag_in;
      tneg_ff <= tneg_in;
      sum_ff  <= sum_in;
      dvd_ff  <= dvd_in;
      v_ff    <= v_in;
   end

endmodule

### src/mwto_front.sv
// ----------------------------------------------------------------------------
// Oscillator front end
// Accepts ticks, keeps phase and run counters, and classifies each sample
// into a multiplier job.
// ----------------------------------------------------------------------------
module mwto_front
   import mwto_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  mwto_cfg_type cfg,
   input  logic         accept,
   input  logic         restart,
   output mwto_job_type job
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam int DW    = $clog2(SINE_TABLE_DEPTH + 1);

   logic signed [33:0] phase_ff, phase_in;
   logic               going_up_ff, going_up_in;
   logic               impulse_sent_ff, impulse_sent_in;
   logic [32:0]        index_ff, index_in;

   logic signed [33:0] eff_phase, nxt_phase;
   logic               eff_up, nxt_up;
   logic               eff_imp, nxt_imp;
   logic [32:0]        eff_index, total;
   logic [31:0]        p32;
   logic               in_tone, in_sil, fin;
   logic [32+DW-1:0]   idx_prod;
   logic [IDX_W-1:0]   sine_idx;
   logic [32:0]        wrap_sum;
   logic signed [33:0] wrap_phase;
   logic signed [35:0] tri_up, tri_dn, ramp_sum;

   always_comb begin
      eff_phase = restart ? '0 : phase_ff;
      eff_up    = restart || going_up_ff;
      eff_imp   = !restart && impulse_sent_ff;
      eff_index = restart ? '0 : index_ff;
      p32       = eff_phase[31:0];
      total     = 33'(cfg.tone_samples) + 33'(cfg.silence_samples);
      in_tone   = eff_index < 33'(cfg.tone_samples);
      in_sil    = !in_tone && (eff_index < total);
      fin       = !in_tone && !in_sil;
      idx_prod  = (32 + DW)'(p32) * (32 + DW)'(SINE_TABLE_DEPTH);
      sine_idx  = idx_prod[32 +: IDX_W];
      wrap_sum  = {1'b0, p32} + {2'b00, cfg.freq_step};
      // overflow drops the remainder
      wrap_phase = wrap_sum[32] ? '0 : signed'({2'b00, wrap_sum[31:0]});
      tri_up    = 36'(eff_phase) + {3'b000, cfg.freq_step, 2'b00};
      tri_dn    = 36'(eff_phase) - {3'b000, cfg.freq_step, 2'b00};
      ramp_sum  = 36'(eff_phase) + {4'b0000, cfg.freq_step, 1'b0};
   end

   always_comb begin
      nxt_phase       = eff_phase;
      nxt_up          = eff_up;
      nxt_imp         = eff_imp;
      job.is_sine     = 1'b0;
      job.operand     = '0;
      job.in_silence  = in_sil;
      job.last_sample = !fin && ((eff_index + 33'd1) == total);
      job.finished    = fin;
      if (in_tone) begin
         case (cfg.wave_mode)
            WAVE_SINE: begin
               job.is_sine = 1'b1;
               job.operand = 34'(sine_idx);
               nxt_phase   = signed'({2'b00, wrap_sum[31:0]});
            end
            WAVE_DC: begin
               job.operand = PHASE_HALF;
            end
            WAVE_SILENT: begin
               job.operand = '0;
            end
            WAVE_SQUARE: begin
               job.operand = p32[31] ? -PHASE_HALF : PHASE_HALF;
               nxt_phase   = wrap_phase;
            end
            WAVE_TRIANGLE: begin
               job.operand = eff_phase;
               if (eff_up) begin
                  if (tri_up >= WIDE_HALF) begin
                     nxt_phase = PHASE_HALF;
                     nxt_up    = 1'b0;
                  end else begin
                     nxt_phase = tri_up[33:0];
                  end
               end else begin
                  if (tri_dn <= -WIDE_HALF) begin
                     nxt_phase = -PHASE_HALF;
                     nxt_up    = 1'b1;
                  end else begin
                     nxt_phase = tri_dn[33:0];
                  end
               end
            end
            WAVE_RAMP: begin
               job.operand = eff_phase;
               nxt_phase   = (ramp_sum >= WIDE_HALF) ? -PHASE_HALF : ramp_sum[33:0];
            end
            WAVE_IMPULSE: begin
               job.operand = eff_imp ? '0 : PHASE_HALF;
               nxt_imp     = 1'b1;
            end
            WAVE_PULSE: begin
               job.operand = (p32 == '0) ? PHASE_HALF : '0;
               nxt_phase   = wrap_phase;
            end
            default: begin
               job.operand = '0;
            end
         endcase
      end
   end

   always_comb begin
      phase_in        = accept ? nxt_phase : phase_ff;
      going_up_in     = accept ? nxt_up : going_up_ff;
      impulse_sent_in = accept ? nxt_imp : impulse_sent_ff;
      index_in        = index_ff;
      if (accept) begin
         index_in = fin ? eff_index : eff_index + 33'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= '0;
         going_up_ff     <= 1'b1;
         impulse_sent_ff <= 1'b0;
         index_ff        <= '0;
      end else begin
         phase_ff        <= phase_in;
         going_up_ff     <= going_up_in;
         impulse_sent_ff <= impulse_sent_in;
         index_ff        <= index_in;
      end
   end

endmodule

### src/mwto_back.sv
// ----------------------------------------------------------------------------
// Oscillator back end
// Reads the sine table, multiplies by the amplitude, rounds and saturates,
// and writes finished words into the result queue.
// ----------------------------------------------------------------------------
module mwto_back
   import mwto_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int SAMPLE_WIDTH     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [15:0]                  amplitude,
   input  mwto_job_type                        job,
   input  logic                                job_valid,
   output logic                                job_pop,
   output logic [$clog2(SINE_TABLE_DEPTH)-1:0] rd_addr,
   input  logic [TABLE_WIDTH-1:0]              rd_data,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]      out_count,
   output logic                                out_push,
   output logic [SAMPLE_WIDTH+2:0]             out_word
);

   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
   localparam int CNT_W   = $clog2(OUT_DEPTH + 1);
   localparam int SHIFT   = 46 - (SAMPLE_WIDTH - 1);
   localparam logic signed [49:0] ROUND_BIAS = 50'sd1 <<< (SHIFT - 1);
   localparam logic signed [49:0] SAMPLE_HI  = (50'sd1 <<< (SAMPLE_WIDTH - 1)) - 50'sd1;
   localparam logic signed [49:0] SAMPLE_LO  = -(50'sd1 <<< (SAMPLE_WIDTH - 1));

   logic               st1_valid_ff, st1_valid_in;
   mwto_job_type       st1_job_ff;
   logic               st2_valid_ff, st2_valid_in;
   logic signed [49:0] st2_prod_ff, st2_prod_in;
   logic [2:0]         st2_flags_ff;

   logic [CNT_W:0]     in_flight;
   logic signed [33:0] factor;
   logic signed [49:0] biased, quot, clamped;

   // issue only when the result queue has room for everything in flight
   assign in_flight = (CNT_W + 1)'(out_count) + (CNT_W + 1)'(st1_valid_ff)
                    + (CNT_W + 1)'(st2_valid_ff);
   assign job_pop   = job_valid && (in_flight < (CNT_W + 1)'(OUT_DEPTH));
   assign rd_addr   = job.operand[IDX_W-1:0];

   always_comb begin
      st1_valid_in = job_pop;
      st2_valid_in = st1_valid_ff;
      factor       = st1_job_ff.is_sine ? signed'({{2{rd_data[15]}}, rd_data, 16'h0000})
                                        : st1_job_ff.operand;
      st2_prod_in  = 50'(amplitude) * 50'(factor);
   end

   // round to nearest, ties up, then saturate
   always_comb begin
      biased  = st2_prod_ff + ROUND_BIAS;
      quot    = biased >>> SHIFT;
      clamped = quot;
      if (quot > SAMPLE_HI) begin
         clamped = SAMPLE_HI;
      end else if (quot < SAMPLE_LO) begin
         clamped = SAMPLE_LO;
      end
      out_push = st2_valid_ff;
      out_word = {clamped[SAMPLE_WIDTH-1:0], st2_flags_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= st1_valid_in;
         st2_valid_ff <= st2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st1_job_ff   <= job;
      st2_prod_ff  <= st2_prod_in;
      st2_flags_ff <= {st1_job_ff.in_silence, st1_job_ff.last_sample, st1_job_ff.finished};
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Test oscillator testbench
// Programs the oscillator over its register port and pushes tick words, some
// with restart set. A scoreboard predicts every output sample from its own
// copy of the registers, phase and sample counter. Directed settings cover the
// sine, square, triangle, ramp, impulse and pulse waveforms, the extremes and
// the empty run. Random phases follow, with bursty sending and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
   import mwto_pkg::*;

   localparam int    CYCLE_LIMIT = 1_000_000;
   localparam int    RANDOM_TICKS = 650;
   localparam longint ANG_PI     = 64'sd3373259426;
   localparam longint ANG_TWOPI  = 64'sd6746518852;
   localparam longint ANG_HALFPI = 64'sd1686629713;
   localparam longint ANG_3HALF  = 64'sd5059889139;
   localparam longint Q30_ONE    = 64'sd1073741824;
   localparam longint UNIT       = 64'sd32768;
   localparam longint HALF_TURN  = 64'sd2147483648;
   localparam longint FULL_TURN  = 64'sd4294967296;
   localparam longint LOW32      = 64'sd4294967295;

   typedef struct packed {
      logic [15:0] sample;
      logic        in_silence;
      logic        last_sample;
      logic        finished;
   } tick_word_type;

   class oscillator_scoreboard;
      shortint        sine_rom[1024];
      mwto_wave_type  wave_sel;
      longint         gain;
      longint         step;
      longint unsigned tone_len;
      longint unsigned rest_len;
      longint         acc;
      bit             rising;
      bit             impulse_done;
      longint unsigned tick_count;
      tick_word_type  expected_words[$];
      int             errors;

      function new();
         longint x, s, v;
         for (longint k = 0; k < 1024; k++) begin
            x = (k * ANG_TWOPI) / 1024;
            s = taylor_sine(x);
            v = s * 32767;
            v = (v >= 0) ? (v + Q30_ONE / 2) / Q30_ONE : (v - Q30_ONE / 2) / Q30_ONE;
            if (v > 32767) v = 32767;
            if (v < -32767) v = -32767;
            sine_rom[k] = shortint'(v);
         end
         wave_sel   = WAVE_SINE;
         gain       = longint'(AMPLITUDE_RESET);
         step       = longint'(FREQ_RESET);
         tone_len   = TONE_RESET;
         rest_len   = SILENCE_RESET;
         clear_run();
         errors     = 0;
      endfunction

      function longint taylor_sine(longint angle);
         longint x, x2, term, sum;
         x = angle;
         if (x > ANG_HALFPI) begin
            if (x < ANG_3HALF) x = ANG_PI - x;
            else x = x - ANG_TWOPI;
         end
         x2 = (x * x) / Q30_ONE;
         term = x;
         sum = x;
         for (int n = 1; n < 15; n += 2) begin
            term = -((term * x2) / Q30_ONE) / longint'((n + 1) * (n + 2));
            sum += term;
         end
         return sum;
      endfunction

      function void clear_run();
         acc          = 0;
         rising       = 1'b1;
         impulse_done = 1'b0;
         tick_count   = 0;
      endfunction

      // round half up, then clamp to the 16-bit sample range
      function longint round_sat(longint prod, int shift);
         longint q;
         q = (prod + (longint'(1) <<< (shift - 1))) >>> shift;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q;
      endfunction

      function void wrap_advance();
         acc = (acc & LOW32) + step;
         if (acc >= FULL_TURN) acc = 0;
      endfunction

      function longint wave_value();
         longint p32, out;
         int idx;
         p32 = acc & LOW32;
         out = 0;
         case (wave_sel)
            WAVE_SINE: begin
               idx = int'(p32 >> 22);
               out = round_sat(gain * longint'(sine_rom[idx]), 15);
               acc = (p32 + step) & LOW32;
            end
            WAVE_DC: out = round_sat(gain * UNIT, 15);
            WAVE_SQUARE: begin
               out = round_sat(gain * ((p32 >= HALF_TURN) ? -UNIT : UNIT), 15);
               wrap_advance();
            end
            WAVE_TRIANGLE: begin
               out = round_sat(gain * acc, 31);
               if (rising) begin
                  acc += 4 * step;
                  if (acc >= HALF_TURN) begin
                     rising = 1'b0;
                     acc = HALF_TURN;
                  end
               end else begin
                  acc -= 4 * step;
                  if (acc <= -HALF_TURN) begin
                     rising = 1'b1;
                     acc = -HALF_TURN;
                  end
               end
            end
            WAVE_RAMP: begin
               out = round_sat(gain * acc, 31);
               acc += 2 * step;
               if (acc >= HALF_TURN) acc = -HALF_TURN;
            end
            WAVE_IMPULSE: begin
               out = impulse_done ? 0 : round_sat(gain * UNIT, 15);
               impulse_done = 1'b1;
            end
            WAVE_PULSE: begin
               out = (p32 == 0) ? round_sat(gain * UNIT, 15) : 0;
               wrap_advance();
            end
            default: out = 0;
         endcase
         return out;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_WAVE_MODE:       wave_sel = mwto_wave_type'(value[2:0]);
            REG_AMPLITUDE:       gain = longint'($signed(value[15:0]));
            REG_FREQ_STEP:       step = longint'(value[30:0]);
            REG_TONE_SAMPLES:    tone_len = value;
            REG_SILENCE_SAMPLES: rest_len = value;
            default: ;
         endcase
      endfunction

      function tick_word_type predict_tick(bit restart);
         longint unsigned total;
         tick_word_type w;
         total = tone_len + rest_len;
         if (restart) clear_run();
         w = '0;
         if (tick_count < tone_len) w.sample = 16'(wave_value());
         else if (tick_count < total) w.in_silence = 1'b1;
         else w.finished = 1'b1;
         if (!w.finished) begin
            if (tick_count + 1 == total) w.last_sample = 1'b1;
            tick_count++;
         end
         return w;
      endfunction

      function void note_tick(bit restart);
         expected_words.push_back(predict_tick(restart));
      endfunction

      function void check_word(tick_word_type got);
         tick_word_type want;
         if (expected_words.size() == 0) begin
            $display("%0t: expected no word, got sample %0d sil %b last %b fin %b",
                     $time, $signed(got.sample), got.in_silence, got.last_sample,
                     got.finished);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (got !== want) begin
            $display("%0t: expected sample %0d sil %b last %b fin %b",
                     $time, $signed(want.sample), want.in_silence, want.last_sample,
                     want.finished);
            $display("%0t: actual   sample %0d sil %b last %b fin %b",
                     $time, $signed(got.sample), got.in_silence, got.last_sample,
                     got.finished);
            errors++;
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_restart = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [15:0] rsp_sample;
   logic        rsp_in_silence;
   logic        rsp_last_sample;
   logic        rsp_finished;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   oscillator_scoreboard tick_board = new();
   bit   restart_plan[$];
   int   rx_style = 0;
   int   stall_left = 0;
   int   cycle_count = 0;
   int   random_sent = 0;

   multi_waveform_test_oscillator u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_restart     (req_restart),
      .empty           (empty),
      .pop             (pop),
      .rsp_sample      (rsp_sample),
      .rsp_in_silence  (rsp_in_silence),
      .rsp_last_sample (rsp_last_sample),
      .rsp_finished    (rsp_finished),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multi_waveform_test_oscillator: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) tick_board.note_tick(req_restart);
         if (pop && !empty)
            tick_board.check_word(tick_word_type'({rsp_sample, rsp_in_silence,
                                                   rsp_last_sample, rsp_finished}));
      end
   end

   // receiver: stall pattern chosen per phase
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (stall_left > 0) begin
         pop <= 1'b0;
         stall_left--;
      end else begin
         pop <= 1'b1;
         if (rx_style == 2 && $urandom_range(0, 1) == 0)
            stall_left = $urandom_range(1, 10);
         else if (rx_style == 1 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 4);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tick_board.set_reg(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_oscillator(mwto_wave_type mode, logic signed [15:0] amp,
                                     logic [30:0] freq, logic [31:0] tone,
                                     logic [31:0] rest);
      csr_write(REG_WAVE_MODE, {29'b0, mode});
      csr_write(REG_AMPLITUDE, {{16{amp[15]}}, amp});
      csr_write(REG_FREQ_STEP, {1'b0, freq});
      csr_write(REG_TONE_SAMPLES, tone);
      csr_write(REG_SILENCE_SAMPLES, rest);
   endtask

   // push the planned ticks in bursts, then wait until every word is back
   task automatic run_ticks();
      int burst, gap;
      while (restart_plan.size() > 0) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && restart_plan.size() > 0) begin
            push        <= 1'b1;
            req_restart <= restart_plan[0];
            @(posedge clock);
            while (full) @(posedge clock);
            void'(restart_plan.pop_front());
            burst--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (restart_plan.size() > 0 && gap > 0) begin
            push        <= 1'b0;
            req_restart <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      push <= 1'b0;
      repeat (2) @(posedge clock);
      while (tick_board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase();
      logic [15:0] amp;
      logic [30:0] freq;
      logic [31:0] tone, rest;
      int n_ticks;
      case ($urandom_range(0, 11))
         0, 1:    amp = 16'h8000;
         2, 3:    amp = 16'h7FFF;
         4:       amp = 16'h0000;
         default: amp = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0:       freq = '0;
         1:       freq = '1;
         2, 3:    freq = 31'($urandom_range(0, 1 << 24));
         default: freq = 31'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       tone = '1;
         1:       tone = $urandom;
         default: tone = $urandom_range(0, 40);
      endcase
      case ($urandom_range(0, 9))
         0:       rest = '1;
         1:       rest = $urandom;
         2, 3:    rest = '0;
         default: rest = $urandom_range(1, 10);
      endcase
      program_oscillator(mwto_wave_type'($urandom_range(0, 7)), amp, freq, tone, rest);
      rx_style = $urandom_range(0, 2);
      n_ticks = $urandom_range(15, 50);
      // mostly restart at the head of a phase; otherwise carry phase and count over
      restart_plan.push_back($urandom_range(0, 3) != 0);
      for (int i = 1; i < n_ticks; i++) restart_plan.push_back($urandom_range(0, 19) == 0);
      run_ticks();
      random_sent += n_ticks;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, first tick without restart
      restart_plan = '{1'b0, 1'b1, 1'b0};
      run_ticks();

      // square at full step, most negative gain: saturates, then silence and done
      program_oscillator(WAVE_SQUARE, 16'sh8000, 31'h7FFF_FFFF, 32'd4, 32'd2);
      rx_style = 1;
      restart_plan = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      run_ticks();

      // triangle reaches the top and turns
      program_oscillator(WAVE_TRIANGLE, 16'sh7FFF, 31'h1000_0000, 32'd8, 32'd0);
      restart_plan = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      run_ticks();

      // ramp reads the triangle phase, then the run ends
      program_oscillator(WAVE_RAMP, 16'sd12345, 31'h2000_0000, 32'd8, 32'd0);
      restart_plan = '{1'b0, 1'b0, 1'b0};
      run_ticks();

      program_oscillator(WAVE_IMPULSE, 16'sh8000, 31'd0, 32'd2, 32'd1);
      rx_style = 2;
      restart_plan = '{1'b1, 1'b0, 1'b0};
      run_ticks();

      program_oscillator(WAVE_PULSE, 16'sh7FFF, 31'h4000_0000, 32'd6, 32'd0);
      restart_plan = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      run_ticks();

      // empty run: every tick reports finished
      program_oscillator(WAVE_DC, 16'sh8000, 31'd0, 32'd0, 32'd0);
      restart_plan = '{1'b1, 1'b0};
      run_ticks();

      while (random_sent < RANDOM_TICKS) random_phase();

      repeat (8) @(posedge clock);
      if (tick_board.errors == 0 && tick_board.pending() == 0)
         $display("multi_waveform_test_oscillator: match");
      else
         $display("multi_waveform_test_oscillator: mismatch");
      $finish;
   end

endmodule
